// ===== rtl/rrgm_pkg.sv =====
package rrgm_pkg;

  localparam int unsigned NOTE_COUNT     = 128;
  localparam int unsigned VELOCITY_COUNT = 128;
  localparam int unsigned TABLE_DEPTH    = NOTE_COUNT * VELOCITY_COUNT;

  localparam int unsigned GROUP_W  = 7;
  localparam int unsigned FIELD_W  = 8;
  localparam int unsigned QUERY_W  = 9;
  localparam int unsigned KIND_W   = 2;

  localparam int unsigned NOTE_W   = $clog2(NOTE_COUNT);
  localparam int unsigned VEL_W    = $clog2(VELOCITY_COUNT);
  // counters that must also hold the table size itself
  localparam int unsigned NOTE_CW  = $clog2(NOTE_COUNT + 1);
  localparam int unsigned VEL_CW   = $clog2(VELOCITY_COUNT + 1);
  localparam int unsigned ADDR_W   = $clog2(TABLE_DEPTH);

  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

endpackage

// ===== rtl/rrgm_ram.sv =====
module rrgm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/round_robin_group_map.sv =====
// Query: result registered in the cycle after the accept (in range) or at the accept
//   edge (outside the table). Add: walk reads one cell per cycle through the table RAM's
//   single read port and writes each back the cycle after; a skipped add ends at accept.
// Clear: a sweep over all TABLE_DEPTH (16384) cells writing zeros, one cell per cycle.
// Reset: control state clears at once, then the same sweep zeroes the table; no
//   request is taken until it ends.
module round_robin_group_map (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rrgm_pkg::KIND_W-1:0]      kind_i,
  input  logic [rrgm_pkg::FIELD_W-1:0]     note_low_i,
  input  logic [rrgm_pkg::FIELD_W-1:0]     note_high_i,
  input  logic [rrgm_pkg::FIELD_W-1:0]     velocity_low_i,
  input  logic [rrgm_pkg::FIELD_W-1:0]     velocity_high_i,
  input  logic [rrgm_pkg::GROUP_W-1:0]     group_number_i,
  input  logic                             unusable_i,
  input  logic signed [rrgm_pkg::QUERY_W-1:0] query_note_i,
  input  logic signed [rrgm_pkg::QUERY_W-1:0] query_velocity_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rrgm_pkg::GROUP_W-1:0]     group_found_o,
  output logic                             in_range_o
);
  import rrgm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_QWAIT = 2'd2;
  localparam logic [1:0] ST_CLEAR = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic               pend_q, pend_d;
  logic [ADDR_W-1:0]  wr_addr_q, wr_addr_d;
  logic               out_valid_q, out_valid_d;
  logic [GROUP_W-1:0] group_found_q, group_found_d;
  logic               in_range_q, in_range_d;

  logic [NOTE_CW-1:0] n_q, n_d, n_end_q, n_end_d;
  logic [VEL_CW-1:0]  v_q, v_d, v_lo_q, v_lo_d, v_end_q, v_end_d;
  logic [ADDR_W-1:0]  base_q, base_d;
  logic [GROUP_W-1:0] grp_q, grp_d;

  logic               accept;
  logic [NOTE_CW-1:0] n0, n1;
  logic [VEL_CW-1:0]  v0, v1;
  logic               add_go;
  logic               q_in_range;
  logic [ADDR_W-1:0]  q_addr;
  logic [VEL_CW-1:0]  v_next;
  logic [NOTE_CW-1:0] n_next;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [GROUP_W-1:0] ram_wdata, ram_rdata;

  assign in_ready_o = (state_q == ST_IDLE) && !pend_q &&
                      (!out_valid_q || out_ready_i || (kind_i != KIND_QUERY));
  assign accept = in_valid_i && in_ready_o;

  // saturate range ends to the table size
  always_comb begin
    n0 = ({1'b0, note_low_i} > (FIELD_W+1)'(NOTE_COUNT)) ?
         NOTE_CW'(NOTE_COUNT) : NOTE_CW'(note_low_i);
    n1 = ({1'b0, note_high_i} > (FIELD_W+1)'(NOTE_COUNT)) ?
         NOTE_CW'(NOTE_COUNT) : NOTE_CW'(note_high_i);
    v0 = ({1'b0, velocity_low_i} > (FIELD_W+1)'(VELOCITY_COUNT)) ?
         VEL_CW'(VELOCITY_COUNT) : VEL_CW'(velocity_low_i);
    v1 = ({1'b0, velocity_high_i} > (FIELD_W+1)'(VELOCITY_COUNT)) ?
         VEL_CW'(VELOCITY_COUNT) : VEL_CW'(velocity_high_i);
  end

  assign add_go = accept && (kind_i == KIND_ADD) && !unusable_i && (n0 < n1) && (v0 < v1);

  assign q_in_range = !query_note_i[QUERY_W-1] && !query_velocity_i[QUERY_W-1] &&
                      ({1'b0, query_note_i[QUERY_W-2:0]} < QUERY_W'(NOTE_COUNT)) &&
                      ({1'b0, query_velocity_i[QUERY_W-2:0]} < QUERY_W'(VELOCITY_COUNT));
  assign q_addr = ADDR_W'(ADDR_W'(query_note_i[NOTE_W-1:0]) * ADDR_W'(VELOCITY_COUNT)) +
                  ADDR_W'(query_velocity_i[VEL_W-1:0]);

  assign v_next = v_q + VEL_CW'(1);
  assign n_next = n_q + NOTE_CW'(1);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = q_addr;
    if (state_q == ST_WALK) begin
      ram_re    = 1'b1;
      ram_raddr = base_q + ADDR_W'(v_q);
    end else if (accept && (kind_i == KIND_QUERY) && q_in_range) begin
      ram_re = 1'b1;
    end
  end

  // write-back of the previous walk cell, or the clearing sweep
  always_comb begin
    ram_we    = pend_q || (state_q == ST_CLEAR);
    ram_waddr = (state_q == ST_CLEAR) ? clr_q : wr_addr_q;
    if (state_q == ST_CLEAR) begin
      ram_wdata = '0;
    end else begin
      ram_wdata = (grp_q > ram_rdata) ? grp_q : ram_rdata;
    end
  end

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    pend_d        = 1'b0;
    wr_addr_d     = ram_raddr;
    out_valid_d   = out_valid_q && !out_ready_i;
    group_found_d = group_found_q;
    in_range_d    = in_range_q;
    n_d           = n_q;
    n_end_d       = n_end_q;
    v_d           = v_q;
    v_lo_d        = v_lo_q;
    v_end_d       = v_end_q;
    base_d        = base_q;
    grp_d         = grp_q;

    case (state_q)
      ST_IDLE: begin
        if (add_go) begin
          n_d     = n0;
          n_end_d = n1;
          v_d     = v0;
          v_lo_d  = v0;
          v_end_d = v1;
          base_d  = ADDR_W'(ADDR_W'(n0) * ADDR_W'(VELOCITY_COUNT));
          grp_d   = group_number_i;
          state_d = ST_WALK;
        end else if (accept && (kind_i == KIND_CLEAR)) begin
          clr_d   = '0;
          state_d = ST_CLEAR;
        end else if (accept && (kind_i == KIND_QUERY)) begin
          if (q_in_range) begin
            state_d = ST_QWAIT;
          end else begin
            out_valid_d   = 1'b1;
            group_found_d = '0;
            in_range_d    = 1'b0;
          end
        end
      end
      ST_WALK: begin
        pend_d = 1'b1;
        if (v_next == v_end_q) begin
          v_d    = v_lo_q;
          n_d    = n_next;
          base_d = base_q + ADDR_W'(VELOCITY_COUNT);
          if (n_next == n_end_q) begin
            state_d = ST_IDLE;
          end
        end else begin
          v_d = v_next;
        end
      end
      ST_QWAIT: begin
        out_valid_d   = 1'b1;
        group_found_d = ram_rdata;
        in_range_d    = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q     <= wr_addr_d;
    group_found_q <= group_found_d;
    in_range_q    <= in_range_d;
    n_q           <= n_d;
    n_end_q       <= n_end_d;
    v_q           <= v_d;
    v_lo_q        <= v_lo_d;
    v_end_q       <= v_end_d;
    base_q        <= base_d;
    grp_q         <= grp_d;
  end

  rrgm_ram #(
    .WIDTH (GROUP_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign group_found_o = group_found_q;
  assign in_range_o    = in_range_q;

  a_rmw_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("walk read hits the cell being written back");

  a_qwait_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QWAIT) |-> !out_valid_q)
    else $error("query result would overwrite a pending result");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !in_range_o) |-> (group_found_o == '0))
    else $error("out-of-range query returned a nonzero group");

  a_query_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KIND_QUERY) && q_in_range) |=> (state_q == ST_QWAIT))
    else $error("in-range query did not wait for table data");

endmodule
